// ===== rtl/aasc_pkg.sv =====
// ----------------------------------------------------------------------------
// aasc_pkg: Alamouti STBC combiner shared definitions
// Sample formats, request/result structs, pipeline stage map and constants.
// ----------------------------------------------------------------------------
package aasc_pkg;

    // Q2.14 samples and gains
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 2;

    // channel table
    localparam int CARRIERS = 64;
    localparam int CAR_W    = 6;
    localparam int IDX_W    = (CARRIERS > 1) ? $clog2(CARRIERS) : 1;

    // datapath widths
    localparam int PROD_W = 2 * SAMPLE_BITS;        // one exact product
    localparam int NUM_W  = PROD_W + 2;             // signed sum of four products
    localparam int MAG_W  = NUM_W - 1;              // |numerator|
    localparam int E_W    = PROD_W + 1;             // sum of four squares
    localparam int N_W    = MAG_W + FRAC_BITS + 1;  // scaled, rounded dividend
    localparam int Q_W    = SAMPLE_BITS;            // quotient bits kept

    localparam int TERMS = 4;
    localparam int LANES = 4;

    // pipeline stage map
    localparam int ST_RD   = 0;                     // table read, request capture
    localparam int ST_PROD = 1;                     // products
    localparam int ST_SUM  = 2;                     // numerator sums, energy
    localparam int ST_PREP = 3;                     // dividend, overflow check
    localparam int ST_DIV0 = 4;                     // first quotient bit
    localparam int ST_LAST = ST_DIV0 + Q_W - 1;     // last quotient bit
    localparam int ST_OUT  = ST_LAST + 1;           // output register

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef logic [CAR_W-1:0]              car_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [E_W-1:0]                energy_t;
    typedef logic [Q_W-1:0]                quo_t;
    typedef logic [ST_OUT:0]               stage_vec_t;

    typedef enum logic
    {
        CMD_DECODE = 1'b0,
        CMD_LOAD   = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t cmd;
        car_t carrier;
        smp_t rx0_re;
        smp_t rx0_im;
        smp_t rx1_re;
        smp_t rx1_im;
        smp_t gain0_re;
        smp_t gain0_im;
        smp_t gain1_re;
        smp_t gain1_im;
    } req_t;

    typedef struct packed
    {
        smp_t sym0_re;
        smp_t sym0_im;
        smp_t sym1_re;
        smp_t sym1_im;
        logic zero_energy;
    } rsp_t;

    typedef struct packed
    {
        smp_t h0_re;
        smp_t h0_im;
        smp_t h1_re;
        smp_t h1_im;
    } chan_t;

    // what one divider lane hands to the merge stage
    typedef struct packed
    {
        quo_t quo;
        logic ovf;
        logic neg;
    } lane_res_t;

    localparam smp_t UNITY = smp_t'(1 << FRAC_BITS);
    localparam smp_t SMAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam smp_t SMIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam quo_t Q_POS_LIM = {1'b0, {(Q_W-1){1'b1}}};
    localparam quo_t Q_NEG_LIM = {1'b1, {(Q_W-1){1'b0}}};

    localparam chan_t UNITY_CHAN = '{h0_re: UNITY, h0_im: '0, h1_re: UNITY, h1_im: '0};

    // per lane, per term: subtract the product instead of adding it
    // lane 0: s0.re, lane 1: s0.im, lane 2: s1.re, lane 3: s1.im
    localparam logic [LANES-1:0][TERMS-1:0] LANE_SUB = {4'b0110, 4'b1100, 4'b1010, 4'b0000};

endpackage

// ===== rtl/aasc_ram.sv =====
// ----------------------------------------------------------------------------
// aasc_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module aasc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

// ===== rtl/aasc_lane.sv =====
// ----------------------------------------------------------------------------
// aasc_lane: one output component of the combiner
// Four products, signed sum, rounding offset, then a pipelined restoring
// divider by the channel energy, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aasc_lane (
    input  logic                                                   clk,
    input  aasc_pkg::stage_vec_t                                   ld,
    input  aasc_pkg::smp_t [aasc_pkg::TERMS-1:0]                   opa,
    input  aasc_pkg::smp_t [aasc_pkg::TERMS-1:0]                   opb,
    input  logic [aasc_pkg::TERMS-1:0]                             sub,
    input  aasc_pkg::energy_t [aasc_pkg::ST_LAST-1:aasc_pkg::ST_SUM] e_pipe,
    output aasc_pkg::lane_res_t                                    res
);

    import aasc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg  [TERMS];
    logic signed [PROD_W-1:0] prod_next [TERMS];
    logic signed [NUM_W-1:0]  acc;
    logic [MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]         mag_next;
    logic                     neg_next;
    logic [N_W-1:0]           n_val;
    logic                     ovf_next;

    logic [E_W-1:0] rem_reg  [ST_PREP:ST_LAST-1];
    logic [E_W-1:0] rem_next [ST_PREP:ST_LAST-1];
    logic [Q_W-1:0] lq_reg   [ST_PREP:ST_LAST];    // dividend low bits out, quotient in
    logic [Q_W-1:0] lq_next  [ST_PREP:ST_LAST];
    logic           neg_reg  [ST_SUM:ST_LAST];
    logic           ovf_reg  [ST_PREP:ST_LAST];

    // products
    always_comb
    begin
        for (int t = 0; t < TERMS; t++)
            prod_next[t] = PROD_W'(opa[t]) * PROD_W'(opb[t]);
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_PROD])
            prod_reg <= prod_next;
    end

    // signed sum, split into sign and magnitude
    always_comb
    begin
        acc = '0;
        for (int t = 0; t < TERMS; t++)
        begin
            if (sub[t])
                acc = acc - NUM_W'(prod_reg[t]);
            else
                acc = acc + NUM_W'(prod_reg[t]);
        end
        neg_next = acc[NUM_W-1];
        mag_next = acc[NUM_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_SUM])
        begin
            mag_reg         <= mag_next;
            neg_reg[ST_SUM] <= neg_next;
        end
    end

    // dividend = |num| * 2^14 + E/2; quotient of 2^Q_W or more saturates anyway
    always_comb
    begin
        n_val             = (N_W'(mag_reg) << FRAC_BITS) + N_W'(e_pipe[ST_SUM] >> 1);
        ovf_next          = (n_val >> Q_W) >= N_W'(e_pipe[ST_SUM]);
        rem_next[ST_PREP] = E_W'(n_val >> Q_W);
        lq_next[ST_PREP]  = n_val[Q_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_PREP])
        begin
            rem_reg[ST_PREP] <= rem_next[ST_PREP];
            lq_reg[ST_PREP]  <= lq_next[ST_PREP];
            neg_reg[ST_PREP] <= neg_reg[ST_SUM];
            ovf_reg[ST_PREP] <= ovf_next;
        end
    end

    for (genvar k = ST_DIV0; k <= ST_LAST; k++)
    begin : g_div
        logic [E_W:0] trial;
        logic         fits;

        assign trial      = {rem_reg[k-1], lq_reg[k-1][Q_W-1]};
        assign fits       = trial >= {1'b0, e_pipe[k-1]};
        assign lq_next[k] = {lq_reg[k-1][Q_W-2:0], fits};

        if (k < ST_LAST)
        begin : g_rem
            assign rem_next[k] = fits ? E_W'(trial - {1'b0, e_pipe[k-1]}) : E_W'(trial);

            always_ff @(posedge clk)
            begin
                if (ld[k])
                    rem_reg[k] <= rem_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                lq_reg[k]  <= lq_next[k];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign res.quo = lq_reg[ST_LAST];
    assign res.ovf = ovf_reg[ST_LAST];
    assign res.neg = neg_reg[ST_LAST];

endmodule

// ===== rtl/aasc_energy.sv =====
// ----------------------------------------------------------------------------
// aasc_energy: channel energy |h0|^2 + |h1|^2
// Computes the divisor once and carries it beside the divider lanes.
// ----------------------------------------------------------------------------
module aasc_energy (
    input  logic                                                   clk,
    input  aasc_pkg::stage_vec_t                                   ld,
    input  aasc_pkg::chan_t                                        h,
    output aasc_pkg::energy_t [aasc_pkg::ST_LAST-1:aasc_pkg::ST_SUM] e_pipe,
    output logic                                                   zero
);

    import aasc_pkg::*;

    logic signed [PROD_W-1:0] sq_reg  [TERMS];
    logic signed [PROD_W-1:0] sq_next [TERMS];
    energy_t                  e_sum;
    energy_t                  e_reg    [ST_SUM:ST_LAST-1];
    logic                     zero_reg [ST_SUM:ST_LAST];

    always_comb
    begin
        sq_next[0] = PROD_W'(h.h0_re) * PROD_W'(h.h0_re);
        sq_next[1] = PROD_W'(h.h0_im) * PROD_W'(h.h0_im);
        sq_next[2] = PROD_W'(h.h1_re) * PROD_W'(h.h1_re);
        sq_next[3] = PROD_W'(h.h1_im) * PROD_W'(h.h1_im);
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_PROD])
            sq_reg <= sq_next;
    end

    // squares are never negative
    always_comb
    begin
        e_sum = '0;
        for (int t = 0; t < TERMS; t++)
            e_sum = e_sum + E_W'($unsigned(sq_reg[t]));
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_SUM])
        begin
            e_reg[ST_SUM]    <= e_sum;
            zero_reg[ST_SUM] <= (e_sum == '0);
        end
    end

    for (genvar k = ST_PREP; k <= ST_LAST; k++)
    begin : g_carry
        if (k < ST_LAST)
        begin : g_e
            always_ff @(posedge clk)
            begin
                if (ld[k])
                    e_reg[k] <= e_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[k])
                zero_reg[k] <= zero_reg[k-1];
        end
    end

    for (genvar k = ST_SUM; k < ST_LAST; k++)
    begin : g_out
        assign e_pipe[k] = e_reg[k];
    end

    assign zero = zero_reg[ST_LAST];

endmodule

// ===== rtl/aasc_merge.sv =====
// ----------------------------------------------------------------------------
// aasc_merge: result assembly
// Applies sign and saturation to each lane quotient, forces zero output on
// zero channel energy, and holds the result register.
// ----------------------------------------------------------------------------
module aasc_merge (
    input  logic                                   clk,
    input  logic                                   ld,
    input  aasc_pkg::lane_res_t [aasc_pkg::LANES-1:0] res,
    input  logic                                   zero,
    output aasc_pkg::rsp_t                         rsp
);

    import aasc_pkg::*;

    smp_t val [LANES];
    rsp_t rsp_reg;
    rsp_t rsp_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            priority if (zero)
                val[l] = '0;
            else if (res[l].neg)
                val[l] = (res[l].ovf || res[l].quo > Q_NEG_LIM) ? SMIN : smp_t'(-res[l].quo);
            else
                val[l] = (res[l].ovf || res[l].quo > Q_POS_LIM) ? SMAX : smp_t'(res[l].quo);
        end
        rsp_next.sym0_re     = val[0];
        rsp_next.sym0_im     = val[1];
        rsp_next.sym1_re     = val[2];
        rsp_next.sym1_im     = val[3];
        rsp_next.zero_energy = zero;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/alamouti_stbc_combiner.sv =====
// ----------------------------------------------------------------------------
// alamouti_stbc_combiner: Alamouti 2x1 STBC combiner, per-carrier gain table
// Throughput: one request per cycle while req_stall is low; a load gives no
// result and is written into the table at acceptance. The stage chain sets the
// depth: table read, products, sums, dividend, one quotient bit per stage,
// output register.
// Reset clears the pipeline and the table's valid bits, so every carrier
// reads 1+0j for both gains until loaded; there is no clearing pass.
// ----------------------------------------------------------------------------
module alamouti_stbc_combiner (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  aasc_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output aasc_pkg::rsp_t rsp_data
);

    import aasc_pkg::*;

    stage_vec_t vld_reg;
    stage_vec_t vld_next;
    stage_vec_t ready;
    stage_vec_t ld;

    logic dec_acc;
    logic load_acc;
    idx_t idx;

    logic [CARRIERS-1:0] tbl_vld_reg;
    logic [CARRIERS-1:0] tbl_vld_next;

    chan_t            load_ent;
    chan_t            ram_q;
    chan_t            h;
    smp_t [3:0]       rx_reg;
    logic             hvld_reg;

    smp_t [TERMS-1:0] opa [LANES];
    smp_t [TERMS-1:0] opb [LANES];
    energy_t [ST_LAST-1:ST_SUM] e_pipe;
    logic             zero;
    lane_res_t [LANES-1:0] lane_res;

    // a stage moves unless it and every stage after it is full and the output stalls
    for (genvar k = 0; k <= ST_OUT; k++)
    begin : g_ready
        assign ready[k] = ~(rsp_stall & (&vld_reg[ST_OUT:k]));
    end

    assign req_stall = ~ready[ST_RD];
    assign dec_acc   = req_valid & ready[ST_RD] & (req_data.cmd == CMD_DECODE);
    assign load_acc  = req_valid & ready[ST_RD] & (req_data.cmd == CMD_LOAD);

    // CARRIERS is a power of two: the modulo is a truncation
    assign idx = IDX_W'(req_data.carrier);

    always_comb
    begin
        vld_next[ST_RD] = ready[ST_RD] ? dec_acc : vld_reg[ST_RD];
        ld[ST_RD]       = dec_acc;
        for (int k = 1; k <= ST_OUT; k++)
        begin
            vld_next[k] = ready[k] ? vld_reg[k-1] : vld_reg[k];
            ld[k]       = ready[k] & vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // channel table
    always_comb
    begin
        tbl_vld_next = tbl_vld_reg;
        if (load_acc)
            tbl_vld_next[idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tbl_vld_reg <= '0;
        else
            tbl_vld_reg <= tbl_vld_next;
    end

    assign load_ent = '{h0_re: req_data.gain0_re, h0_im: req_data.gain0_im,
                        h1_re: req_data.gain1_re, h1_im: req_data.gain1_im};

    aasc_ram #(
        .WIDTH ($bits(chan_t)),
        .DEPTH (CARRIERS)
    ) u_tbl (
        .clk     (clk),
        .wr_en   (load_acc),
        .wr_addr (idx),
        .wr_data (load_ent),
        .rd_en   (dec_acc),
        .rd_addr (idx),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk)
    begin
        if (dec_acc)
        begin
            rx_reg   <= {req_data.rx1_im, req_data.rx1_re, req_data.rx0_im, req_data.rx0_re};
            hvld_reg <= tbl_vld_reg[idx];
        end
    end

    assign h = hvld_reg ? ram_q : UNITY_CHAN;

    // term operands per lane; rx_reg: [0] r0.re, [1] r0.im, [2] r1.re, [3] r1.im
    always_comb
    begin
        opa[0] = {h.h1_im, h.h1_re, h.h0_im, h.h0_re};
        opb[0] = {rx_reg[3], rx_reg[2], rx_reg[1], rx_reg[0]};
        opa[1] = {h.h1_re, h.h1_im, h.h0_im, h.h0_re};
        opb[1] = {rx_reg[3], rx_reg[2], rx_reg[0], rx_reg[1]};
        opa[2] = {h.h0_im, h.h0_re, h.h1_im, h.h1_re};
        opb[2] = {rx_reg[3], rx_reg[2], rx_reg[1], rx_reg[0]};
        opa[3] = {h.h0_re, h.h0_im, h.h1_im, h.h1_re};
        opb[3] = {rx_reg[3], rx_reg[2], rx_reg[0], rx_reg[1]};
    end

    aasc_energy u_energy (
        .clk    (clk),
        .ld     (ld),
        .h      (h),
        .e_pipe (e_pipe),
        .zero   (zero)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        aasc_lane u_lane (
            .clk    (clk),
            .ld     (ld),
            .opa    (opa[l]),
            .opb    (opb[l]),
            .sub    (LANE_SUB[l]),
            .e_pipe (e_pipe),
            .res    (lane_res[l])
        );
    end

    aasc_merge u_merge (
        .clk  (clk),
        .ld   (ld[ST_OUT]),
        .res  (lane_res),
        .zero (zero),
        .rsp  (rsp_data)
    );

    assign rsp_valid = vld_reg[ST_OUT];

endmodule

// ===== rtl/aasc_checker.sv =====
// ----------------------------------------------------------------------------
// aasc_checker: port-level checks for the combiner
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module aasc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input aasc_pkg::rsp_t rsp_data
);

    import aasc_pkg::*;

    ap_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    ap_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_data))
        else $error("result changed while stalled");

    // the request side only backs up when every stage is full and the output stalls
    ap_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid || !rsp_stall |-> !req_stall)
        else $error("request stalled with room in the pipeline");

    ap_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.zero_energy |->
            rsp_data.sym0_re == '0 && rsp_data.sym0_im == '0 &&
            rsp_data.sym1_re == '0 && rsp_data.sym1_im == '0)
        else $error("nonzero symbol with zero channel energy");

endmodule

bind alamouti_stbc_combiner aasc_checker u_aasc_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: Alamouti 2x1 combiner bench
// Drives load and decode requests through the valid/stall handshake and
// checks every decoded symbol pair against an in-bench model of the gain
// table and the rounded, saturated Q2.14 division. The run goes through
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import aasc_pkg::*;

class symbol_scoreboard;

    chan_t gain_table [CARRIERS];
    rsp_t  expected_symbols [$];
    int    errors;

    function new();
        foreach (gain_table[i])
        begin
            gain_table[i] = UNITY_CHAN;
        end
        errors = 0;
    endfunction

    // (|num| * 2^14 + E/2) / E, sign put back, clamped to Q2.14
    function smp_t divide_rounded(longint num, longint unsigned energy);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q   = ((mag << FRAC_BITS) + (energy >> 1)) / energy;
        if (num < 0)
        begin
            return (q > longint'(-longint'(SMIN))) ? SMIN : smp_t'(-longint'(q));
        end
        return (q > longint'(SMAX)) ? SMAX : smp_t'(q);
    endfunction

    function rsp_t combine_pair(req_t request);
        chan_t           h;
        longint          h0r, h0i, h1r, h1i;
        longint          r0r, r0i, r1r, r1i;
        longint unsigned energy;
        rsp_t            symbols;
        h   = gain_table[int'(request.carrier) % CARRIERS];
        h0r = h.h0_re;
        h0i = h.h0_im;
        h1r = h.h1_re;
        h1i = h.h1_im;
        r0r = request.rx0_re;
        r0i = request.rx0_im;
        r1r = request.rx1_re;
        r1i = request.rx1_im;
        energy = h0r * h0r + h0i * h0i + h1r * h1r + h1i * h1i;
        symbols = '0;
        if (energy == 0)
        begin
            symbols.zero_energy = 1'b1;
            return symbols;
        end
        // s0 = conj(h0) r0 + h1 conj(r1), s1 = conj(h1) r0 - h0 conj(r1)
        symbols.sym0_re = divide_rounded(h0r * r0r + h0i * r0i + h1r * r1r + h1i * r1i, energy);
        symbols.sym0_im = divide_rounded(h0r * r0i - h0i * r0r + h1i * r1r - h1r * r1i, energy);
        symbols.sym1_re = divide_rounded(h1r * r0r + h1i * r0i - h0r * r1r - h0i * r1i, energy);
        symbols.sym1_im = divide_rounded(h1r * r0i - h1i * r0r - h0i * r1r + h0r * r1i, energy);
        return symbols;
    endfunction

    function void note_request(req_t request);
        if (request.cmd == CMD_LOAD)
        begin
            gain_table[int'(request.carrier) % CARRIERS] = '{h0_re: request.gain0_re,
                h0_im: request.gain0_im, h1_re: request.gain1_re, h1_im: request.gain1_im};
        end
        else
        begin
            expected_symbols.push_back(combine_pair(request));
        end
    endfunction

    function void compare_field(string name, int expected_value, int actual_value);
        if (expected_value != actual_value)
        begin
            $error("%s: expected %0d, actual %0d", name, expected_value, actual_value);
            errors++;
        end
    endfunction

    function void check_symbols(rsp_t actual);
        rsp_t wanted;
        if (expected_symbols.size() == 0)
        begin
            $error("result with no decode request pending: %h", actual);
            errors++;
            return;
        end
        wanted = expected_symbols.pop_front();
        compare_field("sym0_re", wanted.sym0_re, actual.sym0_re);
        compare_field("sym0_im", wanted.sym0_im, actual.sym0_im);
        compare_field("sym1_re", wanted.sym1_re, actual.sym1_re);
        compare_field("sym1_im", wanted.sym1_im, actual.sym1_im);
        compare_field("zero_energy", wanted.zero_energy, actual.zero_energy);
    endfunction

    function int pending();
        return expected_symbols.size();
    endfunction

endclass

module testbench;

    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    symbol_scoreboard symbols = new();

    alamouti_stbc_combiner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // outputs are stable between the falling edge and the next rising edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                symbols.check_symbols(rsp_data);
            end
        end
    end

    function automatic smp_t random_sample();
        case ($urandom_range(0, 9))
            0:       return SMIN;
            1:       return SMAX;
            2:       return '0;
            3:       return smp_t'($urandom_range(0, 15)) - smp_t'(8);
            default: return smp_t'($urandom());
        endcase
    endfunction

    function automatic req_t random_request();
        req_t request;
        request.cmd      = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_DECODE;
        // a narrow carrier set half the time, so decodes hit fresh loads
        request.carrier  = ($urandom_range(0, 1) == 0) ? car_t'($urandom_range(0, 7))
                                                       : car_t'($urandom());
        request.rx0_re   = random_sample();
        request.rx0_im   = random_sample();
        request.rx1_re   = random_sample();
        request.rx1_im   = random_sample();
        request.gain0_re = random_sample();
        request.gain0_im = random_sample();
        request.gain1_re = random_sample();
        request.gain1_im = random_sample();
        if ($urandom_range(0, 19) == 0)
        begin
            request.gain0_re = '0;
            request.gain0_im = '0;
            request.gain1_re = '0;
            request.gain1_im = '0;
        end
        return request;
    endfunction

    function automatic req_t load_request(int carrier, smp_t g0r, smp_t g0i,
                                          smp_t g1r, smp_t g1i);
        req_t request;
        request          = random_request();
        request.cmd      = CMD_LOAD;
        request.carrier  = car_t'(carrier);
        request.gain0_re = g0r;
        request.gain0_im = g0i;
        request.gain1_re = g1r;
        request.gain1_im = g1i;
        return request;
    endfunction

    function automatic req_t decode_request(int carrier, smp_t r0r, smp_t r0i,
                                            smp_t r1r, smp_t r1i);
        req_t request;
        request         = random_request();
        request.cmd     = CMD_DECODE;
        request.carrier = car_t'(carrier);
        request.rx0_re  = r0r;
        request.rx0_im  = r0i;
        request.rx1_re  = r1r;
        request.rx1_im  = r1i;
        return request;
    endfunction

    task automatic send_request(input req_t request);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= request;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        symbols.note_request(request);
    endtask

    task automatic send_directed();
        // table straight out of reset
        send_request(decode_request(0, UNITY, 0, 0, 0));
        send_request(decode_request(63, SMAX, SMAX, SMAX, SMAX));
        send_request(decode_request(63, SMIN, SMIN, SMIN, SMIN));
        send_request(decode_request(1, SMAX, SMIN, SMIN, SMAX));
        // zero energy
        send_request(load_request(5, 0, 0, 0, 0));
        send_request(decode_request(5, SMAX, SMIN, 1, -1));
        // tiny gain, saturation both ways
        send_request(load_request(7, 1, 0, 0, 0));
        send_request(decode_request(7, SMAX, 0, 0, 0));
        send_request(decode_request(7, SMIN, SMIN, SMIN, SMIN));
        // extreme gains
        send_request(load_request(9, SMIN, SMIN, SMIN, SMIN));
        send_request(decode_request(9, SMAX, SMIN, SMAX, SMIN));
        send_request(decode_request(9, SMIN, SMIN, SMIN, SMIN));
        send_request(load_request(63, SMAX, SMAX, SMAX, SMAX));
        send_request(decode_request(63, SMIN, SMAX, SMAX, SMIN));
        send_request(load_request(0, 0, 1, 0, -1));
        send_request(decode_request(0, 1, -1, 1, 1));
        send_request(decode_request(0, 0, 0, 0, 0));
        // reload a zeroed carrier
        send_request(load_request(5, UNITY, 0, 0, 0));
        send_request(decode_request(5, UNITY, UNITY, SMIN, SMAX));
        // h0 zero, h1 alone
        send_request(load_request(10, 0, 0, SMIN, 0));
        send_request(decode_request(10, SMAX, 1, SMIN, -1));
        send_request(load_request(11, 3, -5, 7, -2));
        send_request(decode_request(11, SMAX, -3, 12, SMIN));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                send_request(random_request());
            end
        end
        req_valid <= 1'b0;

        while (symbols.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (symbols.errors == 0 && symbols.pending() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
